// ===== hdl/wsd_pkg.sv =====
package wsd_pkg;

    // Field widths fixed by the interface.
    localparam int PH_W       = 14;
    localparam int CAL_W      = 2;
    localparam int TOT_W      = 5;
    localparam int CNT_OUT_W  = 5;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 14;

    // Largest reading value.
    localparam longint unsigned PH_MAX = (64'd1 << PH_W) - 64'd1;

    // Default window depth.
    localparam int WINDOW_DEF = 16;

    // Register reset values.
    localparam logic [PH_W-1:0]  TOL_RESET    = 14'd50;
    localparam logic [PH_W-1:0]  OFFSET_RESET = 14'd500;
    localparam int               TOT_RESET    = 16;

    // Calibration targets in milli-pH.
    localparam logic [PH_W-1:0] TARGET_LOW  = 14'd4000;
    localparam logic [PH_W-1:0] TARGET_MID  = 14'd7000;
    localparam logic [PH_W-1:0] TARGET_HIGH = 14'd10000;

    // Item kinds.
    localparam logic KIND_READING = 1'b0;
    localparam logic KIND_CLEAR   = 1'b1;

    typedef enum logic [CAL_W-1:0] {
        CAL_OFF,
        CAL_LOW,
        CAL_MID,
        CAL_HIGH
    } cal_point_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CAL_POINT,
        REG_TOLERANCE,
        REG_MAX_OFFSET,
        REG_STABLE_TOTAL
    } cfg_reg_t;

    // Target value for a calibration point.
    function automatic logic [PH_W-1:0] target_of(input cal_point_t cal);
        logic [PH_W-1:0] t;
        unique case (cal)
            CAL_LOW:  t = TARGET_LOW;
            CAL_MID:  t = TARGET_MID;
            CAL_HIGH: t = TARGET_HIGH;
            default:  t = '0;
        endcase
        return t;
    endfunction

endpackage

// ===== hdl/wsd_ram.sv =====
module wsd_ram #(
    parameter int WIDTH = 14,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port and one registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== hdl/windowed_stability_detector_unit.sv =====
// Channel  | Handshake           | Payload
// ---------+---------------------+----------------------------------------------------
// input    | in_valid / in_stall | kind, ph_mph
// output   | out_valid/out_stall | stable_count, window_count, point_done,
//          |                     | stats_valid, mean_mph
// config   | cfg_we              | cfg_index, cfg_data
//
// A reading steps through the read, update, multiply, compare and decide states, then the
// restoring mean divider, sized by the running-sum width (18 at a window of 16), which is
// skipped below two readings. A clear item or an ignored reading goes straight to done.
// The ring buffer is read, then written back in the next cycle through one RAM.
// rst_n clears the window, the sums and the counts and restores the register defaults.
// A finished transaction waits in the output register while a new one is taken.
module windowed_stability_detector_unit
    import wsd_pkg::*;
#(
    parameter int WINDOW = WINDOW_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic                  kind,
    input  logic [PH_W-1:0]       ph_mph,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [CNT_OUT_W-1:0]  stable_count,
    output logic [CNT_OUT_W-1:0]  window_count,
    output logic                  point_done,
    output logic                  stats_valid,
    output logic [PH_W-1:0]       mean_mph,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int NW = $clog2(WINDOW + 1);
    localparam int PW = $clog2(WINDOW);
    localparam longint unsigned SUM_MAX = 64'(WINDOW) * PH_MAX;
    localparam longint unsigned SQ_MAX  = 64'(WINDOW) * PH_MAX * PH_MAX;
    localparam int SUM_W  = $clog2(SUM_MAX + 64'd1);
    localparam int SQ_W   = $clog2(SQ_MAX + 64'd1);
    localparam int NQ_W   = NW + SQ_W;
    localparam int SS_W   = 2 * SUM_W;
    localparam int TT_W   = 2 * PH_W;
    localparam int NN_W   = 2 * NW;
    localparam int LIM_W  = TT_W + NN_W;
    localparam int CMP_W  = (NQ_W > LIM_W) ? NQ_W : LIM_W;
    localparam int TN_W   = PH_W + NW;
    localparam int DIST_W = (TN_W > SUM_W) ? TN_W : SUM_W;
    localparam int RW     = NW + 1;
    localparam int DC_W   = $clog2(SUM_W);
    localparam int TOT_INIT = (TOT_RESET > WINDOW) ? WINDOW : TOT_RESET;

    typedef enum logic [2:0] {
        S_IDLE,
        S_OLD,
        S_UPD,
        S_MUL,
        S_CMP,
        S_DECIDE,
        S_DIV,
        S_DONE
    } state_t;

    // Configuration registers.
    cal_point_t        cal_point_reg;
    logic [PH_W-1:0]   tolerance_reg;
    logic [PH_W-1:0]   max_offset_reg;
    logic [TOT_W-1:0]  stable_total_reg;
    logic [TOT_W-1:0]  tot_wr;

    // Window state.
    state_t            state_reg;
    logic [PW-1:0]     write_pos_reg;
    logic              ring_full_reg;
    logic [SUM_W-1:0]  sum_reg;
    logic [SQ_W-1:0]   sum_sq_reg;
    logic [TOT_W-1:0]  stable_cnt_reg;
    logic [PH_W-1:0]   mean_reg;

    // Working registers of one reading.
    logic [PH_W-1:0]   ph_reg;
    logic [PH_W-1:0]   old_reg;
    logic [TT_W-1:0]   old_sq_reg;
    logic [TT_W-1:0]   ph_sq_reg;
    logic [NQ_W-1:0]   nq_reg;
    logic [SS_W-1:0]   ss_reg;
    logic [TT_W-1:0]   tt_reg;
    logic [NN_W-1:0]   nn1_reg;
    logic [TN_W-1:0]   tn_reg;
    logic [TN_W-1:0]   mo_reg;
    logic [NQ_W-1:0]   spread_reg;
    logic [LIM_W-1:0]  limit_reg;
    logic [DIST_W-1:0] dist_reg;

    // Divider registers.
    logic [NW-1:0]     rem_reg;
    logic [SUM_W-1:0]  quo_reg;
    logic [DC_W-1:0]   div_cnt_reg;
    logic [RW-1:0]     rem_sh;
    logic              div_fit;
    logic [NW-1:0]     rem_next;
    logic [SUM_W-1:0]  quo_next;

    // Output register.
    logic                 out_valid_reg;
    logic [CNT_OUT_W-1:0] stable_count_reg;
    logic [CNT_OUT_W-1:0] window_count_reg;
    logic                 point_done_reg;
    logic                 stats_valid_reg;
    logic [PH_W-1:0]      mean_out_reg;

    logic [NW-1:0]     held;
    logic              stats_ok;
    logic              stable_ok;
    logic              ram_we;
    logic [PH_W-1:0]   ram_rdata;
    logic              in_take;
    logic              out_free;

    // Ring buffer of readings, read in the cycle before its write-back.
    assign ram_we = (state_reg == S_OLD);

    wsd_ram #(
        .WIDTH (PH_W),
        .DEPTH (WINDOW)
    ) u_ring (
        .clk   (clk),
        .we    (ram_we),
        .waddr (write_pos_reg),
        .wdata (ph_reg),
        .raddr (write_pos_reg),
        .rdata (ram_rdata)
    );

    // Window occupancy and the stability decision.
    assign held      = ring_full_reg ? NW'(WINDOW) : NW'(write_pos_reg);
    assign stats_ok  = (held >= NW'(2));
    assign stable_ok = (CMP_W'(spread_reg) <= CMP_W'(limit_reg))
                    && (dist_reg < DIST_W'(mo_reg));

    // One restoring step of the mean divider.
    assign rem_sh   = {rem_reg, quo_reg[SUM_W-1]};
    assign div_fit  = (rem_sh >= RW'(held));
    assign rem_next = div_fit ? NW'(rem_sh - RW'(held)) : NW'(rem_sh);
    assign quo_next = {quo_reg[SUM_W-2:0], div_fit};

    // Handshakes.
    assign in_stall = (state_reg != S_IDLE);
    assign in_take  = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;

    assign out_valid    = out_valid_reg;
    assign stable_count = stable_count_reg;
    assign window_count = window_count_reg;
    assign point_done   = point_done_reg;
    assign stats_valid  = stats_valid_reg;
    assign mean_mph     = mean_out_reg;

    // Configuration writes; a zero tolerance is ignored and the total is clipped.
    assign tot_wr = cfg_data[TOT_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cal_point_reg    <= CAL_OFF;
            tolerance_reg    <= TOL_RESET;
            max_offset_reg   <= OFFSET_RESET;
            stable_total_reg <= TOT_W'(TOT_INIT);
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_CAL_POINT:
                begin
                    cal_point_reg <= cal_point_t'(cfg_data[CAL_W-1:0]);
                end
                REG_TOLERANCE:
                begin
                    if (cfg_data != '0)
                    begin
                        tolerance_reg <= cfg_data;
                    end
                end
                REG_MAX_OFFSET:
                begin
                    max_offset_reg <= cfg_data;
                end
                REG_STABLE_TOTAL:
                begin
                    if (32'(tot_wr) > 32'(WINDOW))
                    begin
                        stable_total_reg <= TOT_W'(WINDOW);
                    end
                    else
                    begin
                        stable_total_reg <= tot_wr;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // Sequencer: clear the window on a clear item; for a reading, read old sample, update sums, test, divide, report.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            write_pos_reg    <= '0;
            ring_full_reg    <= 1'b0;
            sum_reg          <= '0;
            sum_sq_reg       <= '0;
            stable_cnt_reg   <= '0;
            mean_reg         <= '0;
            out_valid_reg    <= 1'b0;
            stable_count_reg <= '0;
            window_count_reg <= '0;
            point_done_reg   <= 1'b0;
            stats_valid_reg  <= 1'b0;
            mean_out_reg     <= '0;
            ph_reg           <= '0;
            old_reg          <= '0;
            old_sq_reg       <= '0;
            ph_sq_reg        <= '0;
            nq_reg           <= '0;
            ss_reg           <= '0;
            tt_reg           <= '0;
            nn1_reg          <= '0;
            tn_reg           <= '0;
            mo_reg           <= '0;
            spread_reg       <= '0;
            limit_reg        <= '0;
            dist_reg         <= '0;
            rem_reg          <= '0;
            quo_reg          <= '0;
            div_cnt_reg      <= '0;
        end
        else
        begin
            // The output transaction completes when the receiver does not stall;
            // in the done state the output register is reloaded instead.
            if (out_valid_reg && !out_stall && state_reg != S_DONE)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_take)
                    begin
                        ph_reg <= ph_mph;
                        if (kind == KIND_CLEAR)
                        begin
                            write_pos_reg  <= '0;
                            ring_full_reg  <= 1'b0;
                            sum_reg        <= '0;
                            sum_sq_reg     <= '0;
                            stable_cnt_reg <= '0;
                            mean_reg       <= '0;
                            state_reg      <= S_DONE;
                        end
                        else if (cal_point_reg == CAL_OFF)
                        begin
                            state_reg <= S_DONE;
                        end
                        else
                        begin
                            state_reg <= S_OLD;
                        end
                    end
                end

                S_OLD:
                begin
                    // The sample leaving the window counts only once the ring is full.
                    old_reg    <= ring_full_reg ? ram_rdata : '0;
                    old_sq_reg <= ring_full_reg ? TT_W'(ram_rdata) * TT_W'(ram_rdata) : '0;
                    ph_sq_reg  <= TT_W'(ph_reg) * TT_W'(ph_reg);
                    state_reg  <= S_UPD;
                end

                S_UPD:
                begin
                    sum_reg    <= sum_reg - SUM_W'(old_reg) + SUM_W'(ph_reg);
                    sum_sq_reg <= sum_sq_reg - SQ_W'(old_sq_reg) + SQ_W'(ph_sq_reg);
                    if (write_pos_reg == PW'(WINDOW - 1))
                    begin
                        write_pos_reg <= '0;
                        ring_full_reg <= 1'b1;
                    end
                    else
                    begin
                        write_pos_reg <= write_pos_reg + PW'(1);
                    end
                    state_reg <= S_MUL;
                end

                S_MUL:
                begin
                    nq_reg    <= NQ_W'(held) * NQ_W'(sum_sq_reg);
                    ss_reg    <= SS_W'(sum_reg) * SS_W'(sum_reg);
                    tt_reg    <= TT_W'(tolerance_reg) * TT_W'(tolerance_reg);
                    nn1_reg   <= NN_W'(held) * NN_W'(held - NW'(1));
                    tn_reg    <= TN_W'(target_of(cal_point_reg)) * TN_W'(held);
                    mo_reg    <= TN_W'(max_offset_reg) * TN_W'(held);
                    state_reg <= S_CMP;
                end

                S_CMP:
                begin
                    spread_reg <= nq_reg - NQ_W'(ss_reg);
                    limit_reg  <= LIM_W'(tt_reg) * LIM_W'(nn1_reg);
                    if (DIST_W'(tn_reg) >= DIST_W'(sum_reg))
                    begin
                        dist_reg <= DIST_W'(tn_reg) - DIST_W'(sum_reg);
                    end
                    else
                    begin
                        dist_reg <= DIST_W'(sum_reg) - DIST_W'(tn_reg);
                    end
                    state_reg <= S_DECIDE;
                end

                S_DECIDE:
                begin
                    if (stats_ok && stable_ok)
                    begin
                        if (stable_cnt_reg < stable_total_reg)
                        begin
                            stable_cnt_reg <= stable_cnt_reg + TOT_W'(1);
                        end
                    end
                    else
                    begin
                        stable_cnt_reg <= '0;
                    end

                    if (stats_ok)
                    begin
                        rem_reg     <= '0;
                        quo_reg     <= sum_reg;
                        div_cnt_reg <= DC_W'(SUM_W - 1);
                        state_reg   <= S_DIV;
                    end
                    else
                    begin
                        mean_reg  <= '0;
                        state_reg <= S_DONE;
                    end
                end

                S_DIV:
                begin
                    rem_reg     <= rem_next;
                    quo_reg     <= quo_next;
                    div_cnt_reg <= div_cnt_reg - DC_W'(1);
                    if (div_cnt_reg == '0)
                    begin
                        mean_reg  <= quo_next[PH_W-1:0];
                        state_reg <= S_DONE;
                    end
                end

                S_DONE:
                begin
                    // Load the result once the output register is free.
                    if (out_free)
                    begin
                        out_valid_reg    <= 1'b1;
                        stable_count_reg <= CNT_OUT_W'(stable_cnt_reg);
                        window_count_reg <= CNT_OUT_W'(held);
                        point_done_reg   <= (stable_cnt_reg >= stable_total_reg);
                        stats_valid_reg  <= stats_ok;
                        mean_out_reg     <= mean_reg;
                        state_reg        <= S_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // The stable count never passes the window depth.
    assert property (@(posedge clk) disable iff (!rst_n)
        32'(stable_cnt_reg) <= 32'(WINDOW))
        else $error("stable count exceeds window depth");

    // An empty window carries no residue in either running sum.
    assert property (@(posedge clk) disable iff (!rst_n)
        (held == '0) |-> (sum_reg == '0 && sum_sq_reg == '0))
        else $error("running sums nonzero with empty window");

    // With fewer than two readings held the stored mean is zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        !stats_ok |-> (mean_reg == '0))
        else $error("mean nonzero without valid statistics");

    // A reading taken while calibrating goes to the ring read step.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_take && kind == KIND_READING && cal_point_reg != CAL_OFF)
            |=> (state_reg == S_OLD))
        else $error("accepted reading did not start the ring update");

endmodule
